FILE: src/gpa_pkg.sv
// ----------------------------------------------------------------------------
// gpa_pkg
// Types, constants and CORDIC helpers for the gimbal pointing angle pipeline.
// ----------------------------------------------------------------------------
package gpa_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    localparam int CW = 48;   // vectoring x/y width
    localparam int RW = 34;   // rotation x/y width, Q2.30 plus headroom
    localparam int ZW = 34;   // binary angle accumulator
    localparam int TW = 18;   // Q2.14 trig values
    localparam int AW = 30;   // atan table entry width

    localparam logic [2:0] REG_CENTER_U     = 3'd0;
    localparam logic [2:0] REG_CENTER_V     = 3'd1;
    localparam logic [2:0] REG_FOCAL_LENGTH = 3'd2;
    localparam logic [2:0] REG_GAIN_PITCH   = 3'd3;
    localparam logic [2:0] REG_GAIN_YAW     = 3'd4;

    localparam logic signed [RW-1:0] ROT_X0  = RW'(32'sh26DD3B6A);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd2147483648);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zr;   // zero vector
    } t_vec;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 f;    // folded by a half turn
    } t_rot;

    typedef struct packed {
        logic signed [TW-1:0] sp;
        logic signed [TW-1:0] cp;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
    } t_trig;

    typedef struct packed {
        t_vec ep;
        t_vec ey;
        t_rot gp;
        t_rot gy;
    } t_c1;

    typedef struct packed {
        t_rot  ep;
        t_rot  ey;
        t_trig g;
    } t_c2;

    typedef struct packed {
        t_vec tl;
        t_vec pn;
    } t_c3;

    function automatic logic [AW-1:0] atan_bam(input logic [4:0] i);
        case (i)
            5'd0:    return 30'h20000000;
            5'd1:    return 30'h12E4051E;
            5'd2:    return 30'h09FB385B;
            5'd3:    return 30'h051111D4;
            5'd4:    return 30'h028B0D43;
            5'd5:    return 30'h0145D7E1;
            5'd6:    return 30'h00A2F61E;
            5'd7:    return 30'h00517C55;
            5'd8:    return 30'h0028BE53;
            5'd9:    return 30'h00145F2F;
            5'd10:   return 30'h000A2F98;
            5'd11:   return 30'h000517CC;
            5'd12:   return 30'h00028BE6;
            5'd13:   return 30'h000145F3;
            5'd14:   return 30'h0000A2FA;
            5'd15:   return 30'h0000517D;
            5'd16:   return 30'h000028BE;
            5'd17:   return 30'h0000145F;
            5'd18:   return 30'h00000A30;
            5'd19:   return 30'h00000518;
            5'd20:   return 30'h0000028C;
            5'd21:   return 30'h00000146;
            5'd22:   return 30'h000000A3;
            5'd23:   return 30'h00000051;
            default: return '0;
        endcase
    endfunction

    function automatic t_vec vec_init(input logic signed [CW-1:0] y,
                                      input logic signed [CW-1:0] x);
        t_vec r;
        r.zr = (x == '0) && (y == '0);
        r.x  = x;
        r.y  = y;
        r.z  = '0;
        if (x[CW-1]) begin
            if (!y[CW-1]) begin
                r.x = y;
                r.y = -x;
                r.z = QUARTER;
            end else begin
                r.x = -y;
                r.y = x;
                r.z = -QUARTER;
            end
        end
        return r;
    endfunction

    function automatic t_vec vec_step(input t_vec v, input logic [4:0] i);
        t_vec r;
        logic signed [ZW-1:0] a;
        a    = $signed(ZW'(atan_bam(i)));
        r.zr = v.zr;
        if (!v.y[CW-1]) begin
            r.x = v.x + (v.y >>> i);
            r.y = v.y - (v.x >>> i);
            r.z = v.z + a;
        end else begin
            r.x = v.x - (v.y >>> i);
            r.y = v.y + (v.x >>> i);
            r.z = v.z - a;
        end
        return r;
    endfunction

    function automatic t_rot rot_init(input logic [31:0] ang);
        t_rot r;
        logic [31:0] t;
        logic [31:0] a;
        t   = ang + 32'h4000_0000;
        r.f = t[31];
        a   = r.f ? ang + 32'h8000_0000 : ang;
        r.z = ZW'($signed(a));
        r.x = ROT_X0;
        r.y = '0;
        return r;
    endfunction

    function automatic t_rot rot_step(input t_rot v, input logic [4:0] i);
        t_rot r;
        logic signed [ZW-1:0] a;
        a   = $signed(ZW'(atan_bam(i)));
        r.f = v.f;
        if (!v.z[ZW-1]) begin
            r.x = v.x - (v.y >>> i);
            r.y = v.y + (v.x >>> i);
            r.z = v.z - a;
        end else begin
            r.x = v.x + (v.y >>> i);
            r.y = v.y - (v.x >>> i);
            r.z = v.z + a;
        end
        return r;
    endfunction

    // Q2.30 to Q2.14, round half up, then undo the fold
    function automatic logic signed [TW-1:0] rnd_q14(input logic signed [RW-1:0] v,
                                                     input logic f);
        logic signed [RW-1:0] t;
        t = (v + RW'(32'sd32768)) >>> 16;
        t = f ? -t : t;
        return TW'(t);
    endfunction

    function automatic logic signed [TW-1:0] mul_q14(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = (2*TW)'(a) * (2*TW)'(b) + (2*TW)'(32'sd8192);
        return TW'(p >>> 14);
    endfunction

endpackage

FILE: src/gimbal_pointing_angles.sv
// ----------------------------------------------------------------------------
// gimbal_pointing_angles
// Tilt/pan command from target image position and current gimbal attitude.
// ----------------------------------------------------------------------------
// channel   | dir | width | content
// s stream  | in  | 64    | target_u, target_v, gimbal_pitch, gimbal_yaw
// m stream  | out | 32    | tilt_command, pan_command
// cfg write | in  | 16    | center_u, center_v, focal_length, gain_pitch, gain_yaw
//
// One request per cycle while the m side is not stalling; the pipeline holds the
// three CORDIC chains (error atan2, error sin/cos, output atan2) in series.
// Synchronous active-low reset clears the valid bits and loads the config defaults.
// A stall on the m side freezes the whole pipeline; o_s_tready follows it.
// ----------------------------------------------------------------------------
module gimbal_pointing_angles #(
    parameter int CORDIC_STAGES = gpa_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // target_u, target_v, gimbal_pitch, gimbal_yaw
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // tilt_command, pan_command
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import gpa_pkg::*;

    localparam int NS  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int LAT = 3 * NS + 12;
    localparam logic [27:0] DIV_M        = 28'(((64'd1 << 38) + 64'd2249) / 64'd2250);
    localparam logic [16:0] BAM_PER_CDEG = 17'd119304;

    // configuration
    logic signed [15:0] r_center_u;
    logic signed [15:0] r_center_v;
    logic [15:0]        r_focal_length;
    logic [15:0]        r_gain_pitch;
    logic [15:0]        r_gain_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_u     <= '0;
            r_center_v     <= '0;
            r_focal_length <= 16'd1638;
            r_gain_pitch   <= 16'd4096;
            r_gain_yaw     <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CENTER_U:     r_center_u     <= i_cfg_wdata;
                REG_CENTER_V:     r_center_v     <= i_cfg_wdata;
                REG_FOCAL_LENGTH: r_focal_length <= i_cfg_wdata;
                REG_GAIN_PITCH:   r_gain_pitch   <= i_cfg_wdata;
                REG_GAIN_YAW:     r_gain_yaw     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // flow control
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en       = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // stage 1: offsets, centidegree magnitudes
    logic signed [15:0] w_tu, w_tv, w_gp, w_gy;
    logic signed [16:0] w_gpx, w_gyx;
    logic [16:0]        w_mp, w_my;
    logic signed [16:0] r1_du, r1_dv;
    logic [31:0]        r1_hp, r1_hy;
    logic [25:0]        r1_wp, r1_wy;
    logic               r1_sp, r1_sy;

    assign w_tu  = i_s_tdata[15:0];
    assign w_tv  = i_s_tdata[31:16];
    assign w_gp  = i_s_tdata[47:32];
    assign w_gy  = i_s_tdata[63:48];
    assign w_gpx = 17'(w_gp);
    assign w_gyx = 17'(w_gy);
    assign w_mp  = w_gpx[16] ? 17'(-w_gpx) : 17'(w_gpx);
    assign w_my  = w_gyx[16] ? 17'(-w_gyx) : 17'(w_gyx);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_du <= 17'(w_tu) - 17'(r_center_u);
            r1_dv <= 17'(w_tv) - 17'(r_center_v);
            r1_hp <= 32'({17'd0, w_mp} * {17'd0, BAM_PER_CDEG});
            r1_hy <= 32'({17'd0, w_my} * {17'd0, BAM_PER_CDEG});
            r1_wp <= 26'({9'd0, w_mp} * 26'd1456 + 26'd1125);
            r1_wy <= 26'({9'd0, w_my} * 26'd1456 + 26'd1125);
            r1_sp <= w_gp[15];
            r1_sy <= w_gy[15];
        end
    end

    // stage 2: binary angles of the gimbal attitude
    logic [53:0]        w_qp, w_qy;
    logic [31:0]        w_bp, w_by;
    logic [31:0]        r2_bp, r2_by;
    logic signed [16:0] r2_du, r2_dv;

    assign w_qp = {28'd0, r1_wp} * {26'd0, DIV_M};
    assign w_qy = {28'd0, r1_wy} * {26'd0, DIV_M};
    assign w_bp = r1_hp + {16'd0, w_qp[53:38]};
    assign w_by = r1_hy + {16'd0, w_qy[53:38]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_bp <= r1_sp ? 32'd0 - w_bp : w_bp;
            r2_by <= r1_sy ? 32'd0 - w_by : w_by;
            r2_du <= r1_du;
            r2_dv <= r1_dv;
        end
    end

    // chain 1: image error atan2 beside gimbal sin/cos
    t_c1 r_c1 [0:NS];
    logic signed [CW-1:0] w_fx;

    assign w_fx = $signed({{(CW-40){1'b0}}, r_focal_length, 24'd0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1[0].ep <= vec_init($signed(CW'(r2_dv)) <<< 24, w_fx);
            r_c1[0].ey <= vec_init($signed(CW'(r2_du)) <<< 24, w_fx);
            r_c1[0].gp <= rot_init(r2_bp);
            r_c1[0].gy <= rot_init(r2_by);
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_c1
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c1[g+1].ep <= vec_step(r_c1[g].ep, 5'(g));
                r_c1[g+1].ey <= vec_step(r_c1[g].ey, 5'(g));
                r_c1[g+1].gp <= rot_step(r_c1[g].gp, 5'(g));
                r_c1[g+1].gy <= rot_step(r_c1[g].gy, 5'(g));
            end
        end
    end

    // gain stage and gimbal trig rounding
    logic signed [31:0] w_ezp, w_ezy;
    logic signed [48:0] r_e1_pp, r_e1_py;
    t_trig              r_e1_g;

    assign w_ezp = r_c1[NS].ep.zr ? 32'sd0 : r_c1[NS].ep.z[31:0];
    assign w_ezy = r_c1[NS].ey.zr ? 32'sd0 : r_c1[NS].ey.z[31:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_pp   <= 49'(w_ezp) * 49'($signed({1'b0, r_gain_pitch}));
            r_e1_py   <= 49'(w_ezy) * 49'($signed({1'b0, r_gain_yaw}));
            r_e1_g.sp <= rnd_q14(r_c1[NS].gp.y, r_c1[NS].gp.f);
            r_e1_g.cp <= rnd_q14(r_c1[NS].gp.x, r_c1[NS].gp.f);
            r_e1_g.sy <= rnd_q14(r_c1[NS].gy.y, r_c1[NS].gy.f);
            r_e1_g.cy <= rnd_q14(r_c1[NS].gy.x, r_c1[NS].gy.f);
        end
    end

    // chain 2: error sin/cos
    t_c2 r_c2 [0:NS];
    logic signed [48:0] w_gsp, w_gsy;

    assign w_gsp = r_e1_pp + 49'sd2048;
    assign w_gsy = r_e1_py + 49'sd2048;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2[0].ep <= rot_init(w_gsp[43:12]);
            r_c2[0].ey <= rot_init(w_gsy[43:12]);
            r_c2[0].g  <= r_e1_g;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_c2
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c2[g+1].ep <= rot_step(r_c2[g].ep, 5'(g));
                r_c2[g+1].ey <= rot_step(r_c2[g].ey, 5'(g));
                r_c2[g+1].g  <= r_c2[g].g;
            end
        end
    end

    // matrix stages
    t_trig r_m1_g, r_m1_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_g    <= r_c2[NS].g;
            r_m1_e.sp <= rnd_q14(r_c2[NS].ep.y, r_c2[NS].ep.f);
            r_m1_e.cp <= rnd_q14(r_c2[NS].ep.x, r_c2[NS].ep.f);
            r_m1_e.sy <= rnd_q14(r_c2[NS].ey.y, r_c2[NS].ey.f);
            r_m1_e.cy <= rnd_q14(r_c2[NS].ey.x, r_c2[NS].ey.f);
        end
    end

    logic signed [TW-1:0] r_m2_g20, r_m2_g21, r_m2_g00, r_m2_g01;
    logic signed [TW-1:0] r_m2_e01, r_m2_e21, r_m2_e00, r_m2_e20;
    t_trig                r_m2_g, r_m2_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_g20 <= mul_q14(r_m1_g.sp, r_m1_g.cy);
            r_m2_g21 <= mul_q14(r_m1_g.sp, r_m1_g.sy);
            r_m2_g00 <= mul_q14(r_m1_g.cp, r_m1_g.cy);
            r_m2_g01 <= mul_q14(r_m1_g.cp, r_m1_g.sy);
            r_m2_e01 <= mul_q14(r_m1_e.cp, r_m1_e.sy);
            r_m2_e21 <= mul_q14(r_m1_e.sp, r_m1_e.sy);
            r_m2_e00 <= mul_q14(r_m1_e.cp, r_m1_e.cy);
            r_m2_e20 <= mul_q14(r_m1_e.sp, r_m1_e.cy);
            r_m2_g   <= r_m1_g;
            r_m2_e   <= r_m1_e;
        end
    end

    logic signed [2*TW-1:0] r_m3_a1, r_m3_a2, r_m3_a3, r_m3_b1, r_m3_b2;
    logic signed [2*TW-1:0] r_m3_c1, r_m3_c2, r_m3_d1, r_m3_d2, r_m3_d3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m3_a1 <= (2*TW)'(r_m2_g20) * (2*TW)'(r_m2_e01);
            r_m3_a2 <= (2*TW)'(r_m2_g21) * (2*TW)'(r_m2_e.cy);
            r_m3_a3 <= (2*TW)'(r_m2_g.cp) * (2*TW)'(r_m2_e21);
            r_m3_b1 <= (2*TW)'(r_m2_g20) * (2*TW)'(-r_m2_e.sp);
            r_m3_b2 <= (2*TW)'(r_m2_g.cp) * (2*TW)'(r_m2_e.cp);
            r_m3_c1 <= (2*TW)'(-r_m2_g.sy) * (2*TW)'(r_m2_e00);
            r_m3_c2 <= (2*TW)'(r_m2_g.cy) * (2*TW)'(-r_m2_e.sy);
            r_m3_d1 <= (2*TW)'(r_m2_g00) * (2*TW)'(r_m2_e00);
            r_m3_d2 <= (2*TW)'(r_m2_g01) * (2*TW)'(-r_m2_e.sy);
            r_m3_d3 <= (2*TW)'(-r_m2_g.sp) * (2*TW)'(r_m2_e20);
        end
    end

    logic signed [37:0] r_m4_p21, r_m4_p22, r_m4_p10, r_m4_p00;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m4_p21 <= 38'(r_m3_a1) + 38'(r_m3_a2) + 38'(r_m3_a3);
            r_m4_p22 <= 38'(r_m3_b1) + 38'(r_m3_b2);
            r_m4_p10 <= 38'(r_m3_c1) + 38'(r_m3_c2);
            r_m4_p00 <= 38'(r_m3_d1) + 38'(r_m3_d2) + 38'(r_m3_d3);
        end
    end

    // chain 3: tilt and pan atan2
    t_c3 r_c3 [0:NS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3[0].tl <= vec_init($signed(CW'(r_m4_p21)) <<< 10,
                                   $signed(CW'(r_m4_p22)) <<< 10);
            r_c3[0].pn <= vec_init($signed(CW'(r_m4_p10)) <<< 10,
                                   $signed(CW'(r_m4_p00)) <<< 10);
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_c3
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c3[g+1].tl <= vec_step(r_c3[g].tl, 5'(g));
                r_c3[g+1].pn <= vec_step(r_c3[g].pn, 5'(g));
            end
        end
    end

    // clamp and scale to centidegrees
    logic signed [ZW-1:0] w_zt, w_zp;
    logic [31:0]          w_at, w_ap;
    logic [47:0]          r_o1_pt, r_o1_pp;
    logic                 r_o1_st, r_o1_sp;

    always_comb begin
        w_zt = r_c3[NS].tl.zr ? '0 : r_c3[NS].tl.z;
        w_zp = r_c3[NS].pn.zr ? '0 : r_c3[NS].pn.z;
        if (w_zt > HALF) w_zt = HALF;
        if (w_zt < -HALF) w_zt = -HALF;
        if (w_zp > HALF) w_zp = HALF;
        if (w_zp < -HALF) w_zp = -HALF;
        w_at = w_zt[ZW-1] ? 32'(-w_zt) : 32'(w_zt);
        w_ap = w_zp[ZW-1] ? 32'(-w_zp) : 32'(w_zp);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o1_pt <= {16'd0, w_at} * 48'd36000;
            r_o1_pp <= {16'd0, w_ap} * 48'd36000;
            r_o1_st <= w_zt[ZW-1];
            r_o1_sp <= w_zp[ZW-1];
        end
    end

    logic [47:0] w_rt, w_rp;
    logic [15:0] r_tilt, r_pan;

    assign w_rt = r_o1_pt + 48'h0000_8000_0000;
    assign w_rp = r_o1_pp + 48'h0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tilt <= r_o1_st ? 16'd0 - w_rt[47:32] : w_rt[47:32];
            r_pan  <= r_o1_sp ? 16'd0 - w_rp[47:32] : w_rp[47:32];
        end
    end

    assign o_m_tdata = {r_pan, r_tilt};

`ifndef SYNTHESIS
    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd18000 &&
                        $signed(o_m_tdata[15:0]) >= -16'sd18000))
        else $error("tilt out of range");

    a_pan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[31:16]) <= 16'sd18000 &&
                        $signed(o_m_tdata[31:16]) >= -16'sd18000))
        else $error("pan out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted request lost");
`endif

endmodule

FILE: dv/tb_gimbal_pointing_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gimbal_pointing_angles
// Streams target positions and gimbal attitudes through the pointing block
// under several register settings and backpressure patterns. Each tilt/pan
// command is compared with a bit-exact CORDIC predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_gimbal_pointing_angles;
    import gpa_pkg::*;

    localparam int STAGES   = 16;
    localparam int LATENCY  = 3 * STAGES + 12;
    localparam int WDOG_MAX = 4000;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] v;
        logic signed [15:0] u;
    } t_target;

    typedef struct packed {
        logic signed [15:0] pan;
        logic signed [15:0] tilt;
    } t_cmd;

    localparam longint ATAN_TBL [24] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;   // target_u, target_v, gimbal_pitch, gimbal_yaw
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // tilt_command, pan_command
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    gimbal_pointing_angles #(.CORDIC_STAGES(STAGES)) uut (.*);

    logic signed [15:0] m_center_u = 0, m_center_v = 0;
    logic [15:0] m_focal = 1638, m_gain_p = 4096, m_gain_y = 4096;

    t_target pending_targets[$];
    t_cmd    expected_cmds[$];
    int      send_idle_pct = 0, recv_idle_pct = 0;
    int      errors = 0;
    int      quiet_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint cdeg_to_bam(longint c);
        longint unsigned mag, b;
        mag = c < 0 ? -c : c;
        b = (mag * 64'd4294967296 + 18000) / 36000;
        return c < 0 ? longint'(32'(-b[31:0])) : longint'(b[31:0]);
    endfunction

    function automatic longint bam_to_cdeg(longint a);
        longint unsigned mag;
        longint c;
        mag = a < 0 ? -a : a;
        c = (mag * 36000 + 64'd2147483648) >> 32;
        return a < 0 ? -c : c;
    endfunction

    function automatic void sincos(logic [31:0] ang, output longint s, output longint c);
        logic   flip;
        logic [31:0] t;
        longint x, y, z, xn;
        x = 'h26DD3B6A;
        y = 0;
        t = ang + 32'h4000_0000;
        flip = t[31];
        if (flip) ang = ang + 32'h8000_0000;
        z = longint'($signed(ang));
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TBL[i];
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TBL[i];
            end
            x = xn;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint atan2_bam(longint y, longint x);
        longint z, t, xn;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 64'sd1073741824;
            end else begin
                x = -y; y = t; z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TBL[i];
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TBL[i];
            end
            x = xn;
        end
        if (z > 64'sd2147483648) z = 64'sd2147483648;
        if (z < -64'sd2147483648) z = -64'sd2147483648;
        return z;
    endfunction

    function automatic longint q14_mul(longint a, longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    function automatic void rotation(output longint m[3][3], input logic [31:0] p,
                                     input logic [31:0] w);
        longint sp, cp, sw, cw;
        sincos(p, sp, cp);
        sincos(w, sw, cw);
        m[0][0] = q14_mul(cp, cw); m[0][1] = q14_mul(cp, sw); m[0][2] = -sp;
        m[1][0] = -sw;             m[1][1] = cw;              m[1][2] = 0;
        m[2][0] = q14_mul(sp, cw); m[2][1] = q14_mul(sp, sw); m[2][2] = cp;
    endfunction

    function automatic logic [31:0] image_error(longint offset, logic [15:0] gain);
        longint a;
        a = atan2_bam(offset * 64'sd16777216, longint'(m_focal) * 64'sd16777216);
        return 32'((a * longint'(gain) + 2048) >>> 12);
    endfunction

    function automatic t_cmd pointing_command(t_target t);
        longint g[3][3], e[3][3], p[3][3];
        t_cmd r;
        logic [31:0] ep, ey;
        ep = image_error(longint'(t.v) - longint'(m_center_v), m_gain_p);
        ey = image_error(longint'(t.u) - longint'(m_center_u), m_gain_y);
        rotation(g, 32'(cdeg_to_bam(longint'(t.pitch))), 32'(cdeg_to_bam(longint'(t.yaw))));
        rotation(e, ep, ey);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                p[i][j] = 0;
                for (int k = 0; k < 3; k++) p[i][j] += g[i][k] * e[k][j];
            end
        r.tilt = 16'(bam_to_cdeg(atan2_bam(p[2][1] * 1024, p[2][2] * 1024)));
        r.pan  = 16'(bam_to_cdeg(atan2_bam(p[1][0] * 1024, p[0][0] * 1024)));
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) expected_cmds.push_back(pointing_command(i_s_tdata));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_targets.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_cmd got, want;
        i_m_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command %h", $time, got);
                    errors++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.tilt !== want.tilt) begin
                        $display("%0t: tilt expected %0d actual %0d", $time, want.tilt, got.tilt);
                        errors++;
                    end
                    if (got.pan !== want.pan) begin
                        $display("%0t: pan expected %0d actual %0d", $time, want.pan, got.pan);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WDOG_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_CENTER_U:     m_center_u = val;
            REG_CENTER_V:     m_center_v = val;
            REG_FOCAL_LENGTH: m_focal    = val;
            REG_GAIN_PITCH:   m_gain_p   = val;
            REG_GAIN_YAW:     m_gain_y   = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] cu, logic [15:0] cv, logic [15:0] f,
                             logic [15:0] gp, logic [15:0] gy);
        write_reg(REG_CENTER_U, cu);
        write_reg(REG_CENTER_V, cv);
        write_reg(REG_FOCAL_LENGTH, f);
        write_reg(REG_GAIN_PITCH, gp);
        write_reg(REG_GAIN_YAW, gy);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(36000) - 18000);
    endfunction

    function automatic t_target mk(int u, int v, int p, int y);
        t_target t;
        t.u = 16'(u); t.v = 16'(v); t.pitch = 16'(p); t.yaw = 16'(y);
        return t;
    endfunction

    task automatic drain();
        wait (pending_targets.size() == 0 && !i_s_tvalid && expected_cmds.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    initial begin
        t_target t;
        int offs;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: field extremes, zero vector, half turns, out-of-range attitude
        pending_targets.push_back(mk(0, 0, 0, 0));
        pending_targets.push_back(mk(32767, 32767, 18000, 18000));
        pending_targets.push_back(mk(-32768, -32768, -18000, -18000));
        pending_targets.push_back(mk(32767, -32768, 9000, -9000));
        pending_targets.push_back(mk(-32768, 32767, -9000, 9000));
        pending_targets.push_back(mk(0, 0, 18000, 0));
        pending_targets.push_back(mk(0, 0, 0, 18000));
        pending_targets.push_back(mk(0, 0, -18000, 0));
        pending_targets.push_back(mk(0, 0, 0, -18000));
        pending_targets.push_back(mk(0, 0, 32767, -32768));
        pending_targets.push_back(mk(100, -100, -32768, 32767));
        pending_targets.push_back(mk(-1, 1, 17999, -17999));
        pending_targets.push_back(mk(1638, -1638, 4500, 13500));
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = ph < 3 ? 14 : (ph < 6 ? 54 : 0);
            recv_idle_pct = ph < 3 ? 54 : (ph < 6 ? 14 : 0);
            case (ph)
                0: configure(0, 0, 1638, 4096, 4096);
                1: configure(16'h7FFF, 16'h8000, 1, 0, 16'hFFFF);
                2: configure(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 0);
                3: configure(0, 0, 0, 4096, 4096);
                4: configure(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
                             16'($urandom), 16'($urandom));
                5: configure(320, 240, 500, 8192, 2048);
                6: configure(16'hFF00, 100, 4096, 4096, 4096);
                default: configure(16'($urandom), 16'($urandom),
                                   16'($urandom_range(4000, 1)),
                                   16'($urandom_range(8192)), 16'($urandom_range(8192)));
            endcase
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(3) != 0) begin
                    // near the image centre; the attitude is mostly in range
                    offs = int'(m_focal) * 2 + 1;
                    t.u = 16'(int'(m_center_u) + int'($urandom_range(2 * offs)) - offs);
                    t.v = 16'(int'(m_center_v) + int'($urandom_range(2 * offs)) - offs);
                end else begin
                    t.u = 16'($urandom);
                    t.v = 16'($urandom);
                end
                t.pitch = rand_angle();
                t.yaw   = rand_angle();
                pending_targets.push_back(t);
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
